### hdl/kebq_pkg.sv
package kebq_pkg;

	localparam int BITMAP_WORDS = 4;
	localparam int MAX_KEY      = 127;
	localparam int WORD_W       = 32;
	localparam int BIT_W        = 5;
	localparam int WIDX_W       = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int KEY_LIMIT    = (MAX_KEY < BITMAP_WORDS * WORD_W - 1) ?
		MAX_KEY : BITMAP_WORDS * WORD_W - 1;

	localparam logic [15:0] RELEASE_FLAG    = 16'h8000;
	localparam logic [15:0] NOTHING_PENDING = 16'hFFFF;

	localparam logic [2:0] REG_IRQ_ENABLE = 3'd0;

	typedef enum logic [1:0] {
		OP_KEY_EVENT = 2'd0,
		OP_POP       = 2'd1,
		OP_CLEAR     = 2'd2,
		OP_CHECK     = 2'd3
	} op_t;

	typedef struct packed {
		logic capture;
		logic scan_next;
		logic apply;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic hit;
		logic scan_last;
	} dp_status_t;

	function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] n;
		n = BIT_W'(WORD_W - 1);
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				n = BIT_W'(i);
			end
		end
		return n;
	endfunction

endpackage

### hdl/kebq_ctrl.sv
module kebq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	output logic                  result_valid,
	input  logic                  result_stall,
	input  kebq_pkg::dp_status_t  status,
	output kebq_pkg::dp_cmd_t     cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   out_free;
	logic   done;

	assign out_free = !result_valid_q || !result_stall;
	assign done     = (status.op != kebq_pkg::OP_POP) || status.hit || status.scan_last;

	assign item_stall   = (state_q == ST_BUSY);
	assign result_valid = result_valid_q;

	always_comb begin
		cmd.capture   = (state_q == ST_IDLE) && item_valid;
		cmd.apply     = (state_q == ST_BUSY) && out_free && done;
		cmd.scan_next = (state_q == ST_BUSY) && !done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (out_free && done) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hdl/kebq_datapath.sv
module kebq_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kebq_pkg::dp_cmd_t    cmd,
	output kebq_pkg::dp_status_t status,
	input  logic                 irq_enable,
	input  logic [1:0]           op,
	input  logic [7:0]           key_index,
	input  logic                 key_down,
	input  logic [15:0]          key_query,
	output logic [15:0]          data,
	output logic                 irq_pulse
);

	kebq_pkg::op_t                   op_q;
	logic [7:0]                      key_q;
	logic                            down_q;
	logic [15:0]                     query_q;
	logic [kebq_pkg::WIDX_W-1:0]     scan_q;
	logic [kebq_pkg::WORD_W-1:0]     rel_q [kebq_pkg::BITMAP_WORDS];
	logic [kebq_pkg::WORD_W-1:0]     prs_q [kebq_pkg::BITMAP_WORDS];
	logic [kebq_pkg::WORD_W-1:0]     hld_q [kebq_pkg::BITMAP_WORDS];
	logic [15:0]                     data_q;
	logic                            irq_q;

	logic                            key_ok;
	logic                            query_ok;
	logic [kebq_pkg::WIDX_W-1:0]     key_w;
	logic [kebq_pkg::WIDX_W-1:0]     query_w;
	logic [kebq_pkg::WORD_W-1:0]     rel_w;
	logic [kebq_pkg::WORD_W-1:0]     prs_w;
	logic                            rel_any;
	logic                            hit;
	logic [kebq_pkg::BIT_W-1:0]      pick_b;
	logic [14:0]                     code;
	logic [15:0]                     result;

	assign key_ok   = key_q <= 8'(kebq_pkg::KEY_LIMIT);
	assign query_ok = query_q <= 16'(kebq_pkg::KEY_LIMIT);
	assign key_w    = key_q[kebq_pkg::BIT_W +: kebq_pkg::WIDX_W];
	assign query_w  = query_q[kebq_pkg::BIT_W +: kebq_pkg::WIDX_W];
	assign rel_w    = rel_q[scan_q];
	assign prs_w    = prs_q[scan_q];
	assign rel_any  = |rel_w;
	assign hit      = rel_any || (|prs_w);
	assign pick_b   = kebq_pkg::lowest_bit(rel_any ? rel_w : prs_w);
	assign code     = 15'({scan_q, pick_b});

	always_comb begin
		status.op        = op_q;
		status.hit       = hit;
		status.scan_last = (scan_q == kebq_pkg::WIDX_W'(kebq_pkg::BITMAP_WORDS - 1));
	end

	always_comb begin
		result = 16'd0;
		case (op_q)
			kebq_pkg::OP_POP: begin
				if (!hit) begin
					result = kebq_pkg::NOTHING_PENDING;
				end else if (rel_any) begin
					result = kebq_pkg::RELEASE_FLAG | {1'b0, code};
				end else begin
					result = {1'b0, code};
				end
			end
			kebq_pkg::OP_CHECK: begin
				result = {15'd0, query_ok & hld_q[query_w][query_q[kebq_pkg::BIT_W-1:0]]};
			end
			default: result = 16'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= kebq_pkg::op_t'(op);
			key_q   <= key_index;
			down_q  <= key_down;
			query_q <= key_query;
		end
		if (cmd.apply) begin
			data_q <= result;
			irq_q  <= (op_q == kebq_pkg::OP_KEY_EVENT) && key_ok && irq_enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			for (int i = 0; i < kebq_pkg::BITMAP_WORDS; i++) begin
				rel_q[i] <= '0;
				prs_q[i] <= '0;
				hld_q[i] <= '0;
			end
		end else begin
			if (cmd.capture) begin
				scan_q <= '0;
			end else if (cmd.scan_next) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.apply) begin
				case (op_q)
					kebq_pkg::OP_KEY_EVENT: begin
						if (key_ok) begin
							if (down_q) begin
								prs_q[key_w][key_q[kebq_pkg::BIT_W-1:0]] <= 1'b1;
								hld_q[key_w][key_q[kebq_pkg::BIT_W-1:0]] <= 1'b1;
							end else begin
								rel_q[key_w][key_q[kebq_pkg::BIT_W-1:0]] <= 1'b1;
								hld_q[key_w][key_q[kebq_pkg::BIT_W-1:0]] <= 1'b0;
							end
						end
					end
					kebq_pkg::OP_POP: begin
						if (hit) begin
							if (rel_any) begin
								rel_q[scan_q][pick_b] <= 1'b0;
							end
							prs_q[scan_q][pick_b] <= 1'b0;
						end
					end
					kebq_pkg::OP_CLEAR: begin
						for (int i = 0; i < kebq_pkg::BITMAP_WORDS; i++) begin
							rel_q[i] <= '0;
							prs_q[i] <= '0;
							hld_q[i] <= '0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign data      = data_q;
	assign irq_pulse = irq_q;

endmodule

### hdl/key_event_bitmap_queue.sv
// channel  | handshake                    | word
// item     | item_valid / item_stall      | op, key_index, key_down, key_query
// result   | result_valid / result_stall  | data, irq_pulse
// config   | APB write/read, pready high  | irq_enable at address 0
//
// Key event, clear and check are accepted, then applied from the busy state once the result is free.
// Pop is accepted, then scans 1 to BITMAP_WORDS bitmap words, stopping at a hit or the last word,
// one word per cycle through the scan counter.
// Reset clears all three bitmaps and irq_enable at once; no clearing pass.
// A new word is accepted while a result waits; a stalled result holds the update.
module key_event_bitmap_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  key_index,
	input  logic        key_down,
	input  logic [15:0] key_query,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] data,
	output logic        irq_pulse,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	kebq_pkg::dp_cmd_t    cmd;
	kebq_pkg::dp_status_t status;
	logic                 irq_enable_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_enable_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
			paddr == kebq_pkg::REG_IRQ_ENABLE) begin
			irq_enable_q <= pwdata[0];
		end
	end

	assign prdata = (paddr == kebq_pkg::REG_IRQ_ENABLE) ? {31'd0, irq_enable_q} : 32'd0;

	kebq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	kebq_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.irq_enable (irq_enable_q),
		.op         (op),
		.key_index  (key_index),
		.key_down   (key_down),
		.key_query  (key_query),
		.data       (data),
		.irq_pulse  (irq_pulse)
	);

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("no busy cycle after an accepted word");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result raised without a word in work");

	a_irq_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && irq_pulse |-> data == 16'd0)
		else $error("interrupt pulse with non-zero data");

	a_no_apply_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> item_stall && !cmd.capture)
		else $error("update issued outside busy state");

endmodule
